// ===== src/cct_pkg.sv =====
// Shared constants for the shape-pair overlap tester.
// No dependencies.
package cct_pkg;

    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_CIRC_CIRC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SEG_CIRC  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STAD_CIRC = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SEG_SEG   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STAD_SEG  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STAD_STAD = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAD_6     = 3'd6;
    localparam logic [MODE_W-1:0] MODE_BAD_7     = 3'd7;

endpackage

// ===== src/capsule_collision_test_core.sv =====
// Shape-pair overlap tester: one hit flag per transfer.
// Throughput one transfer per cycle when the output is not stalled.
// The whole pipeline holds while the output is valid and stalled.
// Synchronous active-low reset clears the stage valid bits; datapath is not reset.
// Depends on cct_pkg, cct_near_seg, cct_seg_cross.
module capsule_collision_test_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [cct_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [COORD_BITS-1:0]       i_a_x0,
    input  logic signed [COORD_BITS-1:0]       i_a_y0,
    input  logic signed [COORD_BITS-1:0]       i_a_x1,
    input  logic signed [COORD_BITS-1:0]       i_a_y1,
    input  logic [COORD_BITS-2:0]              i_a_radius,
    input  logic signed [COORD_BITS-1:0]       i_b_x0,
    input  logic signed [COORD_BITS-1:0]       i_b_y0,
    input  logic signed [COORD_BITS-1:0]       i_b_x1,
    input  logic signed [COORD_BITS-1:0]       i_b_y1,
    input  logic [COORD_BITS-2:0]              i_b_radius,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_hit
);
    import cct_pkg::*;

    localparam int R2W = 2 * COORD_BITS;

    logic                w_en;
    logic [6:1]          r_vld;
    logic [MODE_W-1:0]   r_mode [1:6];
    logic [COORD_BITS-2:0] r_s1_ra, r_s1_rb;
    logic [R2W-1:0]      r_s2_rs2, r_s2_ra2, r_s2_rb2, r_s3_r2;
    logic                r_s5_ss, r_s6_hit;
    logic [COORD_BITS-1:0] n_rs;
    logic                n_hit;
    logic                w_n0, w_n1, w_n2, w_n3, w_lt0, w_lt1, w_lt2, w_lt3, w_ss;

    assign w_en    = !(r_vld[6] && i_stall);
    assign o_stall = r_vld[6] && i_stall;
    assign n_rs    = COORD_BITS'(r_s1_ra) + COORD_BITS'(r_s1_rb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[5:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mode[1] <= i_mode;
            for (int k = 2; k <= 6; k++) begin
                r_mode[k] <= r_mode[k-1];
            end
            r_s1_ra  <= i_a_radius;
            r_s1_rb  <= i_b_radius;
            r_s2_rs2 <= R2W'(n_rs) * R2W'(n_rs);
            r_s2_ra2 <= R2W'(r_s1_ra) * R2W'(r_s1_ra);
            r_s2_rb2 <= R2W'(r_s1_rb) * R2W'(r_s1_rb);
            if (r_mode[2] == MODE_SEG_CIRC) begin
                r_s3_r2 <= r_s2_rb2;
            end else if (r_mode[2] == MODE_STAD_SEG) begin
                r_s3_r2 <= r_s2_ra2;
            end else begin
                r_s3_r2 <= r_s2_rs2;
            end
            r_s5_ss  <= w_ss;
            r_s6_hit <= n_hit;
        end
    end

    always_comb begin
        unique case (r_mode[5])
            MODE_CIRC_CIRC: n_hit = w_lt0;
            MODE_SEG_CIRC:  n_hit = w_n0;
            MODE_STAD_CIRC: n_hit = w_n0;
            MODE_SEG_SEG:   n_hit = r_s5_ss;
            MODE_STAD_SEG:  n_hit = w_n0 || w_n1 || w_n2 || w_n3 || r_s5_ss;
            MODE_STAD_STAD: n_hit = w_n0 || w_n1 || w_n2 || w_n3 || r_s5_ss;
            default:        n_hit = 1'b0;
        endcase
    end

    cct_near_seg #(.COORD_BITS(COORD_BITS)) u_near_b0 (
        .i_clk(i_clk), .i_en(w_en),
        .i_px(i_b_x0), .i_py(i_b_y0),
        .i_s0x(i_a_x0), .i_s0y(i_a_y0), .i_s1x(i_a_x1), .i_s1y(i_a_y1),
        .i_r2(r_s3_r2), .o_near(w_n0), .o_ctr_lt(w_lt0)
    );

    cct_near_seg #(.COORD_BITS(COORD_BITS)) u_near_b1 (
        .i_clk(i_clk), .i_en(w_en),
        .i_px(i_b_x1), .i_py(i_b_y1),
        .i_s0x(i_a_x0), .i_s0y(i_a_y0), .i_s1x(i_a_x1), .i_s1y(i_a_y1),
        .i_r2(r_s3_r2), .o_near(w_n1), .o_ctr_lt(w_lt1)
    );

    cct_near_seg #(.COORD_BITS(COORD_BITS)) u_near_a0 (
        .i_clk(i_clk), .i_en(w_en),
        .i_px(i_a_x0), .i_py(i_a_y0),
        .i_s0x(i_b_x0), .i_s0y(i_b_y0), .i_s1x(i_b_x1), .i_s1y(i_b_y1),
        .i_r2(r_s3_r2), .o_near(w_n2), .o_ctr_lt(w_lt2)
    );

    cct_near_seg #(.COORD_BITS(COORD_BITS)) u_near_a1 (
        .i_clk(i_clk), .i_en(w_en),
        .i_px(i_a_x1), .i_py(i_a_y1),
        .i_s0x(i_b_x0), .i_s0y(i_b_y0), .i_s1x(i_b_x1), .i_s1y(i_b_y1),
        .i_r2(r_s3_r2), .o_near(w_n3), .o_ctr_lt(w_lt3)
    );

    cct_seg_cross #(.COORD_BITS(COORD_BITS)) u_seg_cross (
        .i_clk(i_clk), .i_en(w_en),
        .i_a_x0(i_a_x0), .i_a_y0(i_a_y0), .i_a_x1(i_a_x1), .i_a_y1(i_a_y1),
        .i_b_x0(i_b_x0), .i_b_y0(i_b_y0), .i_b_x1(i_b_x1), .i_b_y1(i_b_y1),
        .o_hit(w_ss)
    );

    assign o_valid = r_vld[6];
    assign o_hit   = r_s6_hit;

`ifndef SYNTHESIS
    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a pending output");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld) && $stable(r_s6_hit))
        else $error("pipeline advanced while output stalled");

    a_bad_mode_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_mode[6] == MODE_BAD_6 || r_mode[6] == MODE_BAD_7)) |-> !o_hit)
        else $error("hit reported for an unused mode");

    a_ctr_lt_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (w_lt0 == w_lt2) && (!w_lt1 || w_n1) && (!w_lt3 || w_n3))
        else $error("endpoint compare disagrees with segment distance");
`endif

endmodule

// ===== src/cct_near_seg.sv =====
// Five-stage point-to-segment squared distance test against a threshold.
// The threshold arrives aligned with stage three. Uses cct_pkg.
module cct_near_seg #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [COORD_BITS-1:0]   i_px,
    input  logic signed [COORD_BITS-1:0]   i_py,
    input  logic signed [COORD_BITS-1:0]   i_s0x,
    input  logic signed [COORD_BITS-1:0]   i_s0y,
    input  logic signed [COORD_BITS-1:0]   i_s1x,
    input  logic signed [COORD_BITS-1:0]   i_s1y,
    input  logic [2*COORD_BITS-1:0]        i_r2,
    output logic                           o_near,
    output logic                           o_ctr_lt
);
    import cct_pkg::*;

    localparam int D  = COORD_BITS + 1;
    localparam int P  = 2 * D;
    localparam int T  = P + 1;
    localparam int CW = 2 * COORD_BITS + 2;
    localparam int H  = CW / 2;
    localparam int W4 = 2 * CW;

    logic signed [D-1:0] r_s1_dx, r_s1_dy, r_s1_wx, r_s1_wy, r_s1_ex, r_s1_ey;
    logic signed [P-1:0] r_s2_tdx, r_s2_tdy, r_s2_lx, r_s2_ly;
    logic signed [P-1:0] r_s2_wxx, r_s2_wyy, r_s2_exx, r_s2_eyy, r_s2_ca, r_s2_cb;
    logic signed [T-1:0] r_s3_t;
    logic [CW-1:0]       r_s3_len, r_s3_d0, r_s3_d1, r_s3_c;
    logic                r_s4_tle0, r_s4_tge, r_s4_d0le, r_s4_d0lt, r_s4_d1le;
    logic [2*H-1:0]      r_s4_chh, r_s4_chl, r_s4_cll;
    logic [2*H-1:0]      r_s4_rhh, r_s4_rhl, r_s4_rlh, r_s4_rll;
    logic                r_s5_near, r_s5_ctr_lt;

    logic signed [T-1:0] n_s3_t, n_s3_len, n_s3_d0, n_s3_d1, n_s3_cr, n_s3_abs;
    logic [CW-1:0]       n_r2;
    logic [W4-1:0]       n_csq, n_rsq;

    always_comb begin
        n_s3_t   = T'(r_s2_tdx) + T'(r_s2_tdy);
        n_s3_len = T'(r_s2_lx) + T'(r_s2_ly);
        n_s3_d0  = T'(r_s2_wxx) + T'(r_s2_wyy);
        n_s3_d1  = T'(r_s2_exx) + T'(r_s2_eyy);
        n_s3_cr  = T'(r_s2_ca) - T'(r_s2_cb);
        n_s3_abs = n_s3_cr[T-1] ? -n_s3_cr : n_s3_cr;
        n_r2     = CW'(i_r2);
        n_csq    = (W4'(r_s4_chh) << (2 * H)) + (W4'(r_s4_chl) << (H + 1)) + W4'(r_s4_cll);
        n_rsq    = (W4'(r_s4_rhh) << (2 * H))
                 + ((W4'(r_s4_rhl) + W4'(r_s4_rlh)) << H) + W4'(r_s4_rll);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_dx <= D'(i_s1x) - D'(i_s0x);
            r_s1_dy <= D'(i_s1y) - D'(i_s0y);
            r_s1_wx <= D'(i_px) - D'(i_s0x);
            r_s1_wy <= D'(i_py) - D'(i_s0y);
            r_s1_ex <= D'(i_px) - D'(i_s1x);
            r_s1_ey <= D'(i_py) - D'(i_s1y);

            r_s2_tdx <= P'(r_s1_wx) * P'(r_s1_dx);
            r_s2_tdy <= P'(r_s1_wy) * P'(r_s1_dy);
            r_s2_lx  <= P'(r_s1_dx) * P'(r_s1_dx);
            r_s2_ly  <= P'(r_s1_dy) * P'(r_s1_dy);
            r_s2_wxx <= P'(r_s1_wx) * P'(r_s1_wx);
            r_s2_wyy <= P'(r_s1_wy) * P'(r_s1_wy);
            r_s2_exx <= P'(r_s1_ex) * P'(r_s1_ex);
            r_s2_eyy <= P'(r_s1_ey) * P'(r_s1_ey);
            r_s2_ca  <= P'(r_s1_dx) * P'(r_s1_wy);
            r_s2_cb  <= P'(r_s1_dy) * P'(r_s1_wx);

            r_s3_t   <= n_s3_t;
            r_s3_len <= n_s3_len[CW-1:0];
            r_s3_d0  <= n_s3_d0[CW-1:0];
            r_s3_d1  <= n_s3_d1[CW-1:0];
            r_s3_c   <= n_s3_abs[CW-1:0];

            r_s4_tle0 <= r_s3_t[T-1] || (r_s3_t == '0);
            r_s4_tge  <= !r_s3_t[T-1] && (r_s3_t[CW-1:0] >= r_s3_len);
            r_s4_d0le <= r_s3_d0 <= n_r2;
            r_s4_d0lt <= r_s3_d0 < n_r2;
            r_s4_d1le <= r_s3_d1 <= n_r2;
            r_s4_chh  <= CW'(r_s3_c[CW-1:H]) * CW'(r_s3_c[CW-1:H]);
            r_s4_chl  <= CW'(r_s3_c[CW-1:H]) * CW'(r_s3_c[H-1:0]);
            r_s4_cll  <= CW'(r_s3_c[H-1:0]) * CW'(r_s3_c[H-1:0]);
            r_s4_rhh  <= CW'(n_r2[CW-1:H]) * CW'(r_s3_len[CW-1:H]);
            r_s4_rhl  <= CW'(n_r2[CW-1:H]) * CW'(r_s3_len[H-1:0]);
            r_s4_rlh  <= CW'(n_r2[H-1:0]) * CW'(r_s3_len[CW-1:H]);
            r_s4_rll  <= CW'(n_r2[H-1:0]) * CW'(r_s3_len[H-1:0]);

            r_s5_near   <= r_s4_tle0 ? r_s4_d0le : (r_s4_tge ? r_s4_d1le : (n_csq <= n_rsq));
            r_s5_ctr_lt <= r_s4_d0lt;
        end
    end

    assign o_near   = r_s5_near;
    assign o_ctr_lt = r_s5_ctr_lt;

endmodule

// ===== src/cct_seg_cross.sv =====
// Four-stage segment-segment sign test on cross-product numerators.
// Collinear segments report a hit. Uses cct_pkg.
module cct_seg_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_a_x0,
    input  logic signed [COORD_BITS-1:0] i_a_y0,
    input  logic signed [COORD_BITS-1:0] i_a_x1,
    input  logic signed [COORD_BITS-1:0] i_a_y1,
    input  logic signed [COORD_BITS-1:0] i_b_x0,
    input  logic signed [COORD_BITS-1:0] i_b_y0,
    input  logic signed [COORD_BITS-1:0] i_b_x1,
    input  logic signed [COORD_BITS-1:0] i_b_y1,
    output logic                         o_hit
);
    import cct_pkg::*;

    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * D;
    localparam int T = P + 1;

    logic signed [D-1:0] r_s1_ax, r_s1_ay, r_s1_bx, r_s1_by, r_s1_cx, r_s1_cy;
    logic signed [P-1:0] r_s2_aybx, r_s2_axby, r_s2_bycx, r_s2_bxcy, r_s2_axcy, r_s2_aycx;
    logic signed [T-1:0] r_s3_den, r_s3_n1, r_s3_n2;
    logic                r_s4_hit;
    logic                n_ok1, n_ok2;

    always_comb begin
        if (r_s3_den > 0) begin
            n_ok1 = !(r_s3_n1 < 0 || r_s3_n1 > r_s3_den);
            n_ok2 = !(r_s3_n2 < 0 || r_s3_n2 > r_s3_den);
        end else begin
            n_ok1 = !(r_s3_n1 > 0 || r_s3_n1 < r_s3_den);
            n_ok2 = !(r_s3_n2 > 0 || r_s3_n2 < r_s3_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_ax <= D'(i_a_x1) - D'(i_a_x0);
            r_s1_ay <= D'(i_a_y1) - D'(i_a_y0);
            r_s1_bx <= D'(i_b_x1) - D'(i_b_x0);
            r_s1_by <= D'(i_b_y1) - D'(i_b_y0);
            r_s1_cx <= D'(i_a_x0) - D'(i_b_x1);
            r_s1_cy <= D'(i_a_y0) - D'(i_b_y1);

            r_s2_aybx <= P'(r_s1_ay) * P'(r_s1_bx);
            r_s2_axby <= P'(r_s1_ax) * P'(r_s1_by);
            r_s2_bycx <= P'(r_s1_by) * P'(r_s1_cx);
            r_s2_bxcy <= P'(r_s1_bx) * P'(r_s1_cy);
            r_s2_axcy <= P'(r_s1_ax) * P'(r_s1_cy);
            r_s2_aycx <= P'(r_s1_ay) * P'(r_s1_cx);

            r_s3_den <= T'(r_s2_aybx) - T'(r_s2_axby);
            r_s3_n1  <= T'(r_s2_bycx) - T'(r_s2_bxcy);
            r_s3_n2  <= T'(r_s2_axcy) - T'(r_s2_aycx);

            r_s4_hit <= n_ok1 && n_ok2;
        end
    end

    assign o_hit = r_s4_hit;

endmodule
